/* hw/rtl/scs_pkg.sv */
// Shared constants, types and helpers of the sliding-window count sketch.
package scs_pkg;

	// Sketch geometry.
	localparam int ROWS    = 4;
	localparam int COL_W   = 10;
	localparam int COLUMNS = 1 << COL_W;
	localparam int DAYS    = 2;
	localparam int BUCKETS = ROWS * COLUMNS;

	// Field and counter widths.
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 32;
	localparam int FUNC_W = 2;
	localparam int STEP_W = 13;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int SUM_W  = CNT_W + $clog2(DAYS) + 1;
	localparam int RANK_W = $clog2(ROWS) + 1;

	// Ranks of the two middle values; they coincide for an odd row count.
	localparam bit ROWS_ODD = (ROWS % 2) != 0;
	localparam int LO_RANK  = ROWS_ODD ? (ROWS - 1) / 2 : ROWS / 2 - 1;
	localparam int HI_RANK  = ROWS_ODD ? (ROWS - 1) / 2 : ROWS / 2;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

	// Request codes.
	localparam logic [FUNC_W-1:0] FUNC_INSERT = FUNC_W'(0);
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = FUNC_W'(1);
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = FUNC_W'(2);

	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

	typedef logic [ADDR_W-1:0]              addr_t;
	typedef logic [COL_W-1:0]               col_t;
	typedef logic [DAYS-1:0][CNT_W-1:0]     word_t;
	typedef logic [ROWS-1:0][CNT_W-1:0]     vals_t;

	// Handshake between the sequencer and the median unit.
	typedef struct packed {
		logic go;
	} med_req_t;

	typedef struct packed {
		logic              valid;
		logic [CNT_W-1:0]  value;
	} med_rsp_t;

	// Column of a hashed index; COLUMNS is a power of two, so this is a mask.
	function automatic col_t col_of(input logic [IDX_W-1:0] idx);
		logic [COL_W+IDX_W-1:0] wide;
		wide = {{COL_W{1'b0}}, idx};
		return wide[COL_W-1:0];
	endfunction

	// Bucket address of a row and column: row * COLUMNS + column.
	function automatic addr_t bucket_addr(input logic [ROW_W-1:0] row, input col_t col);
		return {row, col};
	endfunction

endpackage

/* hw/rtl/scs_mem.sv */
// Bucket memory: one word per bucket, one write and one registered read per cycle.
module scs_mem (
	input  logic             clk,
	input  scs_pkg::addr_t   rd_addr,
	output scs_pkg::word_t   rd_data,
	input  logic             wr_en,
	input  scs_pkg::addr_t   wr_addr,
	input  scs_pkg::word_t   wr_data
);

	scs_pkg::word_t mem [scs_pkg::BUCKETS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read of the entry written in the same cycle returns the new word.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/scs_median.sv */
// Median across rows: rank selection, then mean of the two middle values.
module scs_median (
	input  logic              clk,
	input  logic              arst_n,
	input  scs_pkg::med_req_t req,
	input  scs_pkg::vals_t    vals,
	output scs_pkg::med_rsp_t rsp
);

	logic                              vld_s1;
	logic signed [scs_pkg::CNT_W-1:0]  lo_s1;
	logic signed [scs_pkg::CNT_W-1:0]  hi_s1;
	logic                              vld_s2;
	logic        [scs_pkg::CNT_W-1:0]  res_s2;

	logic signed [scs_pkg::CNT_W-1:0]  lo_sel;
	logic signed [scs_pkg::CNT_W-1:0]  hi_sel;
	logic signed [scs_pkg::CNT_W:0]    pair_sum;
	logic signed [scs_pkg::CNT_W:0]    half;
	logic        [scs_pkg::CNT_W-1:0]  mean;

	// Each value gets a unique rank; ties are broken by row order.
	always_comb begin
		logic [scs_pkg::RANK_W-1:0] rank;
		lo_sel = '0;
		hi_sel = '0;
		for (int i = 0; i < scs_pkg::ROWS; i++) begin
			rank = '0;
			for (int j = 0; j < scs_pkg::ROWS; j++) begin
				if (($signed(vals[j]) < $signed(vals[i])) ||
				    ((vals[j] == vals[i]) && (j < i))) begin
					rank = rank + 1'b1;
				end
			end
			if (rank == scs_pkg::RANK_W'(scs_pkg::LO_RANK)) begin
				lo_sel = $signed(vals[i]);
			end
			if (rank == scs_pkg::RANK_W'(scs_pkg::HI_RANK)) begin
				hi_sel = $signed(vals[i]);
			end
		end
	end

	// Mean truncated toward zero: a negative odd sum rounds up after the shift.
	always_comb begin
		pair_sum = {lo_s1[scs_pkg::CNT_W-1], lo_s1} + {hi_s1[scs_pkg::CNT_W-1], hi_s1};
		half     = pair_sum >>> 1;
		if (pair_sum[scs_pkg::CNT_W] && pair_sum[0]) begin
			half = half + (scs_pkg::CNT_W+1)'(1);
		end
		if (scs_pkg::ROWS_ODD) begin
			mean = lo_s1;
		end else begin
			mean = half[scs_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.go;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		lo_s1  <= lo_sel;
		hi_s1  <= hi_sel;
		res_s2 <= mean;
	end

	assign rsp.valid = vld_s2;
	assign rsp.value = res_s2;

endmodule

/* hw/rtl/sliding_window_count_sketch.sv */
// Top level of the sliding-window count sketch: sequencer, counter update and aging.
//
// Channel   Direction  Signals                                   Transfer
// request   in         start, func, rowN_index, rowN_sign        start high while busy is low
// result    out        done, estimate, insert_total              one-cycle strobe on done
// config    in         cfg_wr_en, cfg_wr_data (aging_step)       written whenever cfg_wr_en is high
//
// An insert keeps busy high through its row updates, aging_step aging reads and a drain state,
// and its result follows in the next cycle; a query reads the rows and waits for the median
// unit; an unused code answers in the next cycle. Every bucket update goes through the memory's
// single write port, one bucket per cycle, so the insert time grows with aging_step. A clear,
// and the clearing pass after reset, sweep all ROWS * COLUMNS buckets with busy high; the
// clear's result comes at the end. The receiver cannot stall, so results are never held back.
module sliding_window_count_sketch (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [scs_pkg::FUNC_W-1:0]        func,
	input  logic [scs_pkg::IDX_W-1:0]         row0_index,
	input  logic [scs_pkg::IDX_W-1:0]         row1_index,
	input  logic [scs_pkg::IDX_W-1:0]         row2_index,
	input  logic [scs_pkg::IDX_W-1:0]         row3_index,
	input  logic                              row0_sign,
	input  logic                              row1_sign,
	input  logic                              row2_sign,
	input  logic                              row3_sign,
	input  logic                              cfg_wr_en,
	input  logic [scs_pkg::STEP_W-1:0]        cfg_wr_data,
	output logic                              done,
	output logic signed [scs_pkg::CNT_W-1:0]  estimate,
	output logic [scs_pkg::CNT_W-1:0]         insert_total
);

	// Sequencer states.
	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_INS   = 3'd2;
	localparam logic [2:0] ST_AGE   = 3'd3;
	localparam logic [2:0] ST_QRY   = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_MED   = 3'd6;

	// Kind of the memory read that is in flight.
	localparam logic [1:0] KIND_INS = 2'd0;
	localparam logic [1:0] KIND_AGE = 2'd1;
	localparam logic [1:0] KIND_QRY = 2'd2;

	logic [2:0]                      state_q;
	logic [scs_pkg::ROW_W-1:0]       row_q;
	logic [scs_pkg::STEP_W-1:0]      age_cnt_q;
	logic [scs_pkg::STEP_W-1:0]      aging_step_q;
	scs_pkg::addr_t                  ptr_q;
	scs_pkg::addr_t                  clr_ptr_q;
	logic                            clr_report_q;
	logic                            is_query_q;
	logic [scs_pkg::CNT_W-1:0]       insert_cnt_q;
	scs_pkg::col_t                   col_q [scs_pkg::ROWS];
	logic [scs_pkg::ROWS-1:0]        sign_q;
	scs_pkg::vals_t                  vals_q;
	logic                            med_go_q;

	// Read-modify-write stage: the bucket whose read data arrives this cycle.
	logic                            pend_s1;
	logic [1:0]                      kind_s1;
	scs_pkg::addr_t                  addr_s1;
	logic [scs_pkg::ROW_W-1:0]       row_s1;
	logic                            sign_s1;

	logic                            done_q;
	logic signed [scs_pkg::CNT_W-1:0] estimate_q;
	logic [scs_pkg::CNT_W-1:0]       total_q;

	scs_pkg::col_t                   col_in [scs_pkg::ROWS];
	logic [scs_pkg::ROWS-1:0]        sign_in;

	scs_pkg::addr_t                  rd_addr;
	scs_pkg::word_t                  rd_data;
	logic                            wr_en;
	scs_pkg::addr_t                  wr_addr;
	scs_pkg::word_t                  wr_data;
	scs_pkg::word_t                  mod_word;
	logic signed [scs_pkg::CNT_W-1:0] row_val;

	logic                            issue;
	logic                            accept;
	logic                            last_row;
	logic                            last_age;
	scs_pkg::addr_t                  ptr_next;
	logic                            clr_last;

	scs_pkg::med_req_t               med_req;
	scs_pkg::med_rsp_t               med_rsp;

	assign col_in[0] = scs_pkg::col_of(row0_index);
	assign col_in[1] = scs_pkg::col_of(row1_index);
	assign col_in[2] = scs_pkg::col_of(row2_index);
	assign col_in[3] = scs_pkg::col_of(row3_index);
	assign sign_in   = {row3_sign, row2_sign, row1_sign, row0_sign};

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign last_row = (row_q == scs_pkg::ROW_W'(scs_pkg::ROWS - 1));
	assign last_age = (age_cnt_q == aging_step_q - 1'b1);
	assign clr_last = (clr_ptr_q == scs_pkg::ADDR_W'(scs_pkg::BUCKETS - 1));
	assign ptr_next = (ptr_q == scs_pkg::ADDR_W'(scs_pkg::BUCKETS - 1)) ? '0 : ptr_q + 1'b1;

	// A read is issued in every cycle of the insert, aging and query phases.
	assign issue = (state_q == ST_INS) || (state_q == ST_AGE) || (state_q == ST_QRY);

	always_comb begin
		if (state_q == ST_AGE) begin
			rd_addr = ptr_q;
		end else begin
			rd_addr = scs_pkg::bucket_addr(row_q, col_q[row_q]);
		end
	end

	// Modify step: step day slot 0 up or down by the row's sign on insert, shift the day slots on aging,
	// and form the signed per-row sum on query.
	always_comb begin
		logic signed [scs_pkg::CNT_W-1:0] slot0;
		logic signed [scs_pkg::SUM_W-1:0] sum;
		logic signed [scs_pkg::CNT_W-1:0] sat_sum;
		slot0    = $signed(rd_data[0]);
		mod_word = rd_data;
		if (kind_s1 == KIND_AGE) begin
			for (int d = scs_pkg::DAYS - 1; d >= 1; d--) begin
				mod_word[d] = rd_data[d-1];
			end
			mod_word[0] = '0;
		end else if (sign_s1) begin
			mod_word[0] = (slot0 == scs_pkg::CNT_MAX) ? slot0 : slot0 + scs_pkg::CNT_W'(1);
		end else begin
			mod_word[0] = (slot0 == scs_pkg::CNT_MIN) ? slot0 : slot0 - scs_pkg::CNT_W'(1);
		end

		sum = '0;
		for (int d = 0; d < scs_pkg::DAYS; d++) begin
			sum = sum + {{(scs_pkg::SUM_W-scs_pkg::CNT_W){rd_data[d][scs_pkg::CNT_W-1]}},
			             rd_data[d]};
		end
		if (sum > $signed({{(scs_pkg::SUM_W-scs_pkg::CNT_W){1'b0}}, scs_pkg::CNT_MAX})) begin
			sat_sum = scs_pkg::CNT_MAX;
		end else if (sum < $signed({{(scs_pkg::SUM_W-scs_pkg::CNT_W){1'b1}},
		                            scs_pkg::CNT_MIN})) begin
			sat_sum = scs_pkg::CNT_MIN;
		end else begin
			sat_sum = sum[scs_pkg::CNT_W-1:0];
		end
		// Negating the most negative count saturates to the largest positive one.
		if (sign_s1) begin
			row_val = sat_sum;
		end else if (sat_sum == scs_pkg::CNT_MIN) begin
			row_val = scs_pkg::CNT_MAX;
		end else begin
			row_val = -sat_sum;
		end
	end

	// The clearing sweep owns the write port; otherwise the modified word goes back.
	always_comb begin
		if (state_q == ST_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_ptr_q;
			wr_data = '0;
		end else begin
			wr_en   = pend_s1 && (kind_s1 != KIND_QRY);
			wr_addr = addr_s1;
			wr_data = mod_word;
		end
	end

	scs_mem u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign med_req.go = med_go_q;

	scs_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (med_req),
		.vals   (vals_q),
		.rsp    (med_rsp)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_step_q <= scs_pkg::STEP_RESET;
		end else if (cfg_wr_en) begin
			aging_step_q <= cfg_wr_data;
		end
	end

	// Sequencer and control state. Reset starts with a clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			row_q        <= '0;
			age_cnt_q    <= '0;
			ptr_q        <= '0;
			clr_ptr_q    <= '0;
			clr_report_q <= 1'b0;
			is_query_q   <= 1'b0;
			insert_cnt_q <= '0;
			pend_s1      <= 1'b0;
			kind_s1      <= KIND_INS;
			med_go_q     <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			med_go_q <= 1'b0;
			pend_s1  <= issue;
			if (issue) begin
				case (state_q)
					ST_AGE:  kind_s1 <= KIND_AGE;
					ST_QRY:  kind_s1 <= KIND_QRY;
					default: kind_s1 <= KIND_INS;
				endcase
			end

			case (state_q)
				ST_CLR: begin
					clr_ptr_q <= clr_ptr_q + 1'b1;
					if (clr_last) begin
						state_q      <= ST_IDLE;
						done_q       <= clr_report_q;
						clr_report_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						row_q     <= '0;
						age_cnt_q <= '0;
						case (func)
							scs_pkg::FUNC_INSERT: begin
								state_q    <= ST_INS;
								is_query_q <= 1'b0;
								if (insert_cnt_q != '1) begin
									insert_cnt_q <= insert_cnt_q + 1'b1;
								end
							end
							scs_pkg::FUNC_QUERY: begin
								state_q    <= ST_QRY;
								is_query_q <= 1'b1;
							end
							scs_pkg::FUNC_CLEAR: begin
								state_q      <= ST_CLR;
								clr_ptr_q    <= '0;
								clr_report_q <= 1'b1;
								insert_cnt_q <= '0;
							end
							default: begin
								// Unused code: report the current count and change nothing.
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_INS: begin
					row_q <= row_q + 1'b1;
					if (last_row) begin
						row_q   <= '0;
						state_q <= (aging_step_q != '0) ? ST_AGE : ST_DRAIN;
					end
				end
				ST_AGE: begin
					ptr_q     <= ptr_next;
					age_cnt_q <= age_cnt_q + 1'b1;
					if (last_age) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_QRY: begin
					row_q <= row_q + 1'b1;
					if (last_row) begin
						row_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (is_query_q) begin
						state_q  <= ST_MED;
						med_go_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_MED: begin
					if (med_rsp.valid) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int r = 0; r < scs_pkg::ROWS; r++) begin
				col_q[r] <= col_in[r];
			end
			sign_q <= sign_in;
		end
		if (issue) begin
			addr_s1 <= rd_addr;
			row_s1  <= row_q;
			sign_s1 <= sign_q[row_q];
		end
		if (pend_s1 && (kind_s1 == KIND_QRY)) begin
			vals_q[row_s1] <= row_val;
		end
		if ((state_q == ST_MED) && med_rsp.valid) begin
			estimate_q <= $signed(med_rsp.value);
		end else begin
			estimate_q <= '0;
		end
		if ((state_q == ST_IDLE) && accept) begin
			total_q <= insert_cnt_q;
		end else if (state_q == ST_CLR) begin
			total_q <= '0;
		end else begin
			total_q <= insert_cnt_q;
		end
	end

	assign done         = done_q;
	assign estimate     = estimate_q;
	assign insert_total = total_q;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sliding-window count sketch: directed and random requests.
module testbench;
	import scs_pkg::*;

	// The unused request code changes nothing and answers with the current insert count.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = FUNC_W'(3);

	// The longest quiet stretch of a correct run is one full sweep of the bucket memory
	// (a clear, the clearing pass after reset, or an insert that ages every bucket).
	// The watchdog allows several times that sweep.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 32;
	localparam int HOT_KEYS       = 8;

	// One request as the sender sees it: the operation plus the externally hashed
	// bucket column and sign for every row.
	typedef struct packed {
		logic [FUNC_W-1:0]             func;
		logic [ROWS-1:0][IDX_W-1:0]    index;
		logic [ROWS-1:0]               sign;
	} sketch_req_t;

	typedef struct packed {
		logic signed [CNT_W-1:0]  estimate;
		logic [CNT_W-1:0]         insert_total;
	} sketch_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [FUNC_W-1:0]           func;
	logic [IDX_W-1:0]            row0_index;
	logic [IDX_W-1:0]            row1_index;
	logic [IDX_W-1:0]            row2_index;
	logic [IDX_W-1:0]            row3_index;
	logic                        row0_sign;
	logic                        row1_sign;
	logic                        row2_sign;
	logic                        row3_sign;
	logic                        cfg_wr_en;
	logic [STEP_W-1:0]           cfg_wr_data;
	logic                        done;
	logic signed [CNT_W-1:0]     estimate;
	logic [CNT_W-1:0]            insert_total;

	// Shadow copy of the sketch state, kept in step with every accepted request.
	logic signed [CNT_W-1:0]  shadow_slot [BUCKETS*DAYS];
	int unsigned              shadow_pointer;
	logic [CNT_W-1:0]         shadow_inserts;
	logic [STEP_W-1:0]        shadow_step;

	// Results still owed by the block, oldest first.
	sketch_result_t  pending_results [$];
	sketch_result_t  oldest;

	sketch_req_t  hot_key [HOT_KEYS];
	int unsigned  idle_pct;
	int unsigned  mismatch_count;
	int unsigned  quiet_cycles;

	sliding_window_count_sketch u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.row0_index   (row0_index),
		.row1_index   (row1_index),
		.row2_index   (row2_index),
		.row3_index   (row3_index),
		.row0_sign    (row0_sign),
		.row1_sign    (row1_sign),
		.row2_sign    (row2_sign),
		.row3_sign    (row3_sign),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.done         (done),
		.estimate     (estimate),
		.insert_total (insert_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Day slots and per-row sums saturate at the signed 32-bit limits.
	function automatic logic signed [CNT_W-1:0] clamp_count(input longint value);
		if (value > longint'(CNT_MAX))
			return CNT_MAX;
		if (value < longint'(CNT_MIN))
			return CNT_MIN;
		return value[CNT_W-1:0];
	endfunction

	// Applies one request to the shadow state and returns the result the block owes for it.
	function automatic sketch_result_t predict_sketch_result(input sketch_req_t req);
		sketch_result_t  result;
		longint          row_value [ROWS];
		longint          sum;
		longint          held;
		longint          median;
		int unsigned     bucket;
		int              r;
		int              d;
		int              n;
		int              c;

		result.estimate = '0;
		case (req.func)
			FUNC_INSERT: begin
				// Count first, then age the buckets under the rotating pointer, so an
				// insert can be shifted out of slot 0 by its own aging pass.
				for (r = 0; r < ROWS; r++) begin
					bucket = r * COLUMNS + req.index[r];
					shadow_slot[bucket*DAYS] = clamp_count(longint'(shadow_slot[bucket*DAYS])
						+ (req.sign[r] ? 1 : -1));
				end
				for (n = 0; n < shadow_step; n++) begin
					for (d = DAYS - 1; d >= 1; d--)
						shadow_slot[shadow_pointer*DAYS+d] = shadow_slot[shadow_pointer*DAYS+d-1];
					shadow_slot[shadow_pointer*DAYS] = '0;
					shadow_pointer = (shadow_pointer + 1) % BUCKETS;
				end
				if (shadow_inserts != '1)
					shadow_inserts++;
			end
			FUNC_QUERY: begin
				for (r = 0; r < ROWS; r++) begin
					bucket = r * COLUMNS + req.index[r];
					sum = 0;
					for (d = 0; d < DAYS; d++)
						sum += shadow_slot[bucket*DAYS+d];
					sum = clamp_count(sum);
					// Negating the most negative count saturates to the most positive one.
					if (!req.sign[r])
						sum = clamp_count(-sum);
					row_value[r] = sum;
				end
				for (r = 1; r < ROWS; r++) begin
					held = row_value[r];
					c = r;
					while (c > 0 && row_value[c-1] > held) begin
						row_value[c] = row_value[c-1];
						c--;
					end
					row_value[c] = held;
				end
				// For an even row count the two middle values are averaged, which
				// truncates toward zero like integer division does.
				if (ROWS % 2 != 0)
					median = row_value[(ROWS-1)/2];
				else
					median = (row_value[ROWS/2-1] + row_value[ROWS/2]) / 2;
				result.estimate = median[CNT_W-1:0];
			end
			FUNC_CLEAR: begin
				// A clear leaves the aging pointer where it was.
				foreach (shadow_slot[i])
					shadow_slot[i] = '0;
				shadow_inserts = '0;
			end
			default: begin
			end
		endcase
		result.insert_total = shadow_inserts;
		return result;
	endfunction

	function automatic sketch_req_t make_request(input logic [FUNC_W-1:0] code,
			input logic [ROWS-1:0][IDX_W-1:0] index, input logic [ROWS-1:0] sign);
		sketch_req_t req;
		req.func = code;
		req.index = index;
		req.sign = sign;
		return req;
	endfunction

	function automatic logic [ROWS-1:0][IDX_W-1:0] random_columns();
		logic [ROWS-1:0][IDX_W-1:0] index;
		int r;
		for (r = 0; r < ROWS; r++)
			index[r] = IDX_W'($urandom);
		return index;
	endfunction

	// Random traffic leans on a few hot keys so that counts build up, age and collide;
	// the rest is scattered noise. Clears are rare because each one sweeps the memory.
	function automatic sketch_req_t random_request();
		sketch_req_t  req;
		int unsigned  roll;
		int unsigned  pick;

		roll = $urandom_range(999);
		if (roll < 15)
			req.func = FUNC_CLEAR;
		else if (roll < 35)
			req.func = FUNC_UNUSED;
		else if (roll < 620)
			req.func = FUNC_INSERT;
		else
			req.func = FUNC_QUERY;
		if ($urandom_range(9) < 7) begin
			pick = $urandom_range(HOT_KEYS - 1);
			req.index = hot_key[pick].index;
			req.sign = hot_key[pick].sign;
			// Querying a hot key with flipped signs gives negative estimates.
			if (req.func == FUNC_QUERY && $urandom_range(9) == 0)
				req.sign = ~req.sign;
		end else begin
			req.index = random_columns();
			req.sign = ROWS'($urandom);
		end
		return req;
	endfunction

	// Sends one request. Called at a falling edge and returns at a falling edge; start is
	// left high so back-to-back requests need no second assignment in the same step.
	task automatic send_request(input sketch_req_t req);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		func <= req.func;
		row0_index <= req.index[0];
		row1_index <= req.index[1];
		row2_index <= req.index[2];
		row3_index <= req.index[3];
		row0_sign <= req.sign[0];
		row1_sign <= req.sign[1];
		row2_sign <= req.sign[2];
		row3_sign <= req.sign[3];
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// Accepted at this edge: predict now, in acceptance order.
		pending_results.push_back(predict_sketch_result(req));
		@(negedge clk);
	endtask

	// Holds the sender off until every owed result has come, then lets the block settle.
	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic set_aging_step(input logic [STEP_W-1:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		shadow_step = value;
		@(negedge clk);
	endtask

	// After the clearing pass the sketch must read as empty.
	task automatic test_idle_after_reset();
		repeat (2)
			@(negedge clk);
		while (busy)
			@(negedge clk);
		send_request(make_request(FUNC_UNUSED, '1, '1));
		send_request(make_request(FUNC_QUERY, '0, '0));
		send_request(make_request(FUNC_QUERY, '1, '1));
	endtask

	// Every operation on the column extremes and on one mixed key.
	task automatic test_operations();
		logic [ROWS-1:0][IDX_W-1:0] mixed;

		mixed = {10'd1023, 10'd700, 10'd2, 10'd513};
		send_request(make_request(FUNC_INSERT, '0, '1));
		send_request(make_request(FUNC_INSERT, '0, '1));
		send_request(make_request(FUNC_INSERT, '1, '0));
		send_request(make_request(FUNC_INSERT, mixed, 4'b0101));
		send_request(make_request(FUNC_QUERY, '0, '1));
		send_request(make_request(FUNC_QUERY, '0, '0));
		send_request(make_request(FUNC_QUERY, '1, '0));
		send_request(make_request(FUNC_QUERY, '1, '1));
		send_request(make_request(FUNC_QUERY, mixed, 4'b0101));
		send_request(make_request(FUNC_UNUSED, mixed, 4'b1010));
		send_request(make_request(FUNC_CLEAR, '0, '0));
		send_request(make_request(FUNC_QUERY, '0, '1));
		send_request(make_request(FUNC_INSERT, '0, '1));
	endtask

	// Aging extremes: no aging at all, a whole sweep per insert, and one bucket short of it.
	task automatic test_aging_step();
		set_aging_step('0);
		send_request(make_request(FUNC_INSERT, '0, '1));
		send_request(make_request(FUNC_QUERY, '0, '1));
		set_aging_step(STEP_W'(BUCKETS));
		send_request(make_request(FUNC_INSERT, {ROWS{10'd5}}, '1));
		send_request(make_request(FUNC_INSERT, {ROWS{10'd5}}, '1));
		send_request(make_request(FUNC_QUERY, {ROWS{10'd5}}, '1));
		set_aging_step(STEP_W'(BUCKETS - 1));
		send_request(make_request(FUNC_INSERT, '1, '1));
		send_request(make_request(FUNC_QUERY, '1, '1));
		set_aging_step(STEP_RESET);
	endtask

	// Random traffic in phases, each with its own aging step and sender idling. The large
	// steps make each insert sweep the memory, so those phases are kept short.
	task automatic test_random_traffic();
		int unsigned step_of [9]  = '{1, 0, 3, 16, 1, 255, 4096, 4095, 7};
		int unsigned pct_of [9]   = '{0, 70, 20, 0, 70, 20, 0, 70, 20};
		int unsigned count_of [9] = '{300, 300, 300, 300, 300, 120, 12, 10, 358};
		int p;
		int k;
		int n;

		for (p = 0; p < 9; p++) begin
			set_aging_step(STEP_W'(step_of[p]));
			idle_pct = pct_of[p];
			for (k = 0; k < HOT_KEYS; k++) begin
				hot_key[k].func = FUNC_INSERT;
				hot_key[k].index = random_columns();
				hot_key[k].sign = ROWS'($urandom);
			end
			for (n = 0; n < count_of[p]; n++) begin
				send_request(random_request());
				// Now and then the sender waits for the block to run dry.
				if ($urandom_range(199) == 0)
					drain();
			end
		end
		idle_pct = 0;
	endtask

	// Every result is matched against the oldest owed one. Outputs are read at the rising
	// edge, before the block's own updates of that edge land.
	task automatic flag_mismatch(input string what, input longint want, input longint got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unrequested result, estimate", 0, longint'(estimate));
			end else begin
				oldest = pending_results.pop_front();
				if (estimate !== oldest.estimate)
					flag_mismatch("estimate", longint'(oldest.estimate), longint'(estimate));
				if (insert_total !== oldest.insert_total)
					flag_mismatch("insert_total", longint'(oldest.insert_total),
						longint'(insert_total));
			end
		end
	end

	// Watchdog: ends the run when neither a request nor a result has moved for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_INSERT;
		row0_index = '0;
		row1_index = '0;
		row2_index = '0;
		row3_index = '0;
		row0_sign = 1'b0;
		row1_sign = 1'b0;
		row2_sign = 1'b0;
		row3_sign = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		idle_pct = 0;
		mismatch_count = 0;
		foreach (shadow_slot[i])
			shadow_slot[i] = '0;
		shadow_pointer = 0;
		shadow_inserts = '0;
		shadow_step = STEP_RESET;
		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;

		test_idle_after_reset();
		test_operations();
		test_aging_step();
		test_random_traffic();

		drain();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
